// File: rtl/core/t8cpu_pkg.sv
// ----------------------------------------------------------------------------
// t8cpu_pkg
// shared types and constants of the tiny 8-bit cpu execute stage
// ----------------------------------------------------------------------------
package t8cpu_pkg;

    localparam int NUM_REGS   = 32;
    localparam int REG_IDX_W  = 5;
    localparam int FLAG_COUNT = 6;

    localparam logic [REG_IDX_W-1:0] REG_IN    = 5'd28;
    localparam logic [REG_IDX_W-1:0] REG_OUT   = 5'd30;
    localparam logic [REG_IDX_W-1:0] REG_FLAGS = 5'd31;
    localparam int                   OVF_BIT   = 4;

    typedef logic [7:0]                 byte_t;
    typedef logic [NUM_REGS-1:0][7:0]   regfile_t;
    typedef logic [REG_IDX_W-1:0]       reg_idx_t;

    // opcodes
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_ATC  = 5'd1;
    localparam logic [4:0] OP_MOV  = 5'd2;
    localparam logic [4:0] OP_SHL  = 5'd3;
    localparam logic [4:0] OP_SHR  = 5'd4;
    localparam logic [4:0] OP_JMP  = 5'd5;
    localparam logic [4:0] OP_JEQ  = 5'd6;
    localparam logic [4:0] OP_JULT = 5'd7;
    localparam logic [4:0] OP_JSLT = 5'd8;
    localparam logic [4:0] OP_JULE = 5'd9;
    localparam logic [4:0] OP_JSLE = 5'd10;
    localparam logic [4:0] OP_UAD  = 5'd11;
    localparam logic [4:0] OP_SAD  = 5'd12;
    localparam logic [4:0] OP_UMT  = 5'd13;
    localparam logic [4:0] OP_SMT  = 5'd14;
    localparam logic [4:0] OP_AND  = 5'd15;
    localparam logic [4:0] OP_OR   = 5'd16;
    localparam logic [4:0] OP_XOR  = 5'd17;

    // addressing modes
    localparam logic [2:0] MODE_REG = 3'd0;
    localparam logic [2:0] MODE_IND = 3'd1;
    localparam logic [2:0] MODE_IN  = 3'd2;
    localparam logic [2:0] MODE_OUT = 3'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_OP   = 2'd1;
    localparam logic [1:0] ST_IMM_DEST = 2'd2;
    localparam logic [1:0] ST_BAD_FLAG = 2'd3;

endpackage

// File: rtl/core/tiny_8bit_cpu_execute.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_execute
// execute stage of a small 8-bit cpu with a 32 x 8 register file
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one decoded instruction per
//   transfer: kind, and mode / value for operands a, b and c
//   output channel (out_valid / out_ready) carries one result per
//   instruction: next_pc, data_out (register 30), flags_now (register 31)
//   and status
//   order: an accepted instruction lands in the input register and
//   executes once the result register can take its result, loading the
//   result register with it; the result register then drives the output
//   channel until it transfers out
//   throughput: one instruction per cycle unless the output stalls; the
//   register file is read and written in the same cycle as the result
//   register loads, so the next instruction sees all writes of the one before it
//   stall: when out_ready is low the result stays in the output register,
//   one more instruction waits in the input register and in_ready falls
//   reset: register file, program counter and halt state clear to zero
//   halt: a nonzero status halts the block; later instructions change
//   nothing and report the state and the halting status until reset
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_execute
    import t8cpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] kind,
    input  logic [2:0] mode_a,
    input  logic [7:0] value_a,
    input  logic [2:0] mode_b,
    input  logic [7:0] value_b,
    input  logic [2:0] mode_c,
    input  logic [7:0] value_c,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] next_pc,
    output logic [7:0] data_out,
    output logic [7:0] flags_now,
    output logic [1:0] status
);

    // operand read: register, indirect through a pointer register, input
    // register, output register, else the value itself
    function automatic byte_t read_op(input logic [2:0] m, input byte_t v,
                                      input regfile_t rf);
        byte_t r;
        case (m)
            MODE_REG: r = rf[v[REG_IDX_W-1:0]];
            MODE_IND: r = rf[rf[v[REG_IDX_W-1:0]][REG_IDX_W-1:0]];
            MODE_IN:  r = rf[REG_IN];
            MODE_OUT: r = rf[REG_OUT];
            default:  r = v;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------------
    logic       in_valid_reg;
    logic [4:0] kind_reg;
    logic [2:0] mode_a_reg, mode_b_reg, mode_c_reg;
    byte_t      value_a_reg, value_b_reg, value_c_reg;

    // architectural state
    regfile_t   rf_reg;
    byte_t      pc_reg;
    logic       halted_reg;
    logic [1:0] halt_code_reg;

    // output register
    logic       out_valid_reg;
    byte_t      next_pc_reg, data_out_reg, flags_now_reg;
    logic [1:0] status_reg;

    // an instruction executes when the result register can take its result
    logic exec;
    assign exec     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg    <= kind;
            mode_a_reg  <= mode_a;
            value_a_reg <= value_a;
            mode_b_reg  <= mode_b;
            value_b_reg <= value_b;
            mode_c_reg  <= mode_c;
            value_c_reg <= value_c;
        end
    end

    // ------------------------------------------------------------------------
    // execute
    // ------------------------------------------------------------------------
    byte_t      op_a, op_b, op_c, dest_val;
    reg_idx_t   dest_a, dest_b, dest_idx;
    logic       dest_a_imm, dest_b_imm;
    logic [8:0] usum;
    logic [8:0] ssum;
    logic [15:0] uprod;
    logic signed [15:0] sprod;

    logic       wr_en;
    reg_idx_t   wr_idx;
    byte_t      wr_data;
    logic       ovf;
    logic       take;
    byte_t      npc;
    logic [1:0] st;
    byte_t      flags_base;
    byte_t      flags_next;
    byte_t      out_reg_next;
    byte_t      pc_next;
    logic       halted_next;
    logic [1:0] halt_code_next;
    regfile_t   rf_next;

    always_comb
    begin
        op_a = read_op(mode_a_reg, value_a_reg, rf_reg);
        op_b = read_op(mode_b_reg, value_b_reg, rf_reg);
        op_c = read_op(mode_c_reg, value_c_reg, rf_reg);

        // destination index decode for operand a and operand b
        dest_a_imm = 1'b0;
        case (mode_a_reg)
            MODE_REG: dest_a = value_a_reg[REG_IDX_W-1:0];
            MODE_IND: dest_a = rf_reg[value_a_reg[REG_IDX_W-1:0]][REG_IDX_W-1:0];
            MODE_IN:  dest_a = REG_IN;
            MODE_OUT: dest_a = REG_OUT;
            default:
            begin
                dest_a     = '0;
                dest_a_imm = 1'b1;
            end
        endcase
        dest_b_imm = 1'b0;
        case (mode_b_reg)
            MODE_REG: dest_b = value_b_reg[REG_IDX_W-1:0];
            MODE_IND: dest_b = rf_reg[value_b_reg[REG_IDX_W-1:0]][REG_IDX_W-1:0];
            MODE_IN:  dest_b = REG_IN;
            MODE_OUT: dest_b = REG_OUT;
            default:
            begin
                dest_b     = '0;
                dest_b_imm = 1'b1;
            end
        endcase

        // accumulate forms read their destination as the first operand
        dest_idx = dest_a;
        dest_val = rf_reg[dest_a];
        usum  = {1'b0, dest_val} + {1'b0, op_b};
        ssum  = {dest_val[7], dest_val} + {op_b[7], op_b};
        uprod = {8'd0, dest_val} * {8'd0, op_b};
        sprod = $signed({{8{dest_val[7]}}, dest_val}) * $signed({{8{op_b[7]}}, op_b});

        wr_en   = 1'b0;
        wr_idx  = dest_idx;
        wr_data = '0;
        ovf     = 1'b0;
        take    = 1'b0;
        npc     = pc_reg + 8'd1;
        st      = ST_OK;

        case (kind_reg)
            OP_NOP:
            begin
            end
            OP_ATC:
            begin
                if (value_a_reg >= 8'(FLAG_COUNT) || value_b_reg >= 8'(FLAG_COUNT))
                begin
                    st = ST_BAD_FLAG;
                end
                else
                begin
                    take    = rf_reg[REG_FLAGS][value_a_reg[2:0]];
                    wr_en   = 1'b1;
                    wr_idx  = REG_FLAGS;
                    wr_data = rf_reg[REG_FLAGS] & ~(8'd1 << value_b_reg[2:0]);
                    if (take)
                    begin
                        npc = '0;
                    end
                end
            end
            OP_MOV, OP_SHL, OP_SHR:
            begin
                if (dest_b_imm)
                begin
                    st = ST_IMM_DEST;
                end
                else
                begin
                    wr_en  = 1'b1;
                    wr_idx = dest_b;
                    if (kind_reg == OP_SHL)
                    begin
                        wr_data = {op_a[6:0], 1'b0};
                    end
                    else if (kind_reg == OP_SHR)
                    begin
                        wr_data = {1'b0, op_a[7:1]};
                    end
                    else
                    begin
                        wr_data = op_a;
                    end
                end
            end
            OP_JMP:
            begin
                npc = op_a;
            end
            OP_JEQ, OP_JULT, OP_JSLT, OP_JULE, OP_JSLE:
            begin
                case (kind_reg)
                    OP_JEQ:  take = (op_a == op_b);
                    OP_JULT: take = (op_a < op_b);
                    OP_JSLT: take = ($signed(op_a) < $signed(op_b));
                    OP_JULE: take = (op_a <= op_b);
                    default: take = ($signed(op_a) <= $signed(op_b));
                endcase
                if (take)
                begin
                    npc = op_c;
                end
            end
            OP_UAD, OP_SAD, OP_UMT, OP_SMT, OP_AND, OP_OR, OP_XOR:
            begin
                if (dest_a_imm)
                begin
                    st = ST_IMM_DEST;
                end
                else
                begin
                    wr_en = 1'b1;
                    case (kind_reg)
                        OP_UAD:
                        begin
                            wr_data = usum[7:0];
                            ovf     = usum[8];
                        end
                        OP_SAD:
                        begin
                            wr_data = ssum[7:0];
                            ovf     = ssum[8] != ssum[7];
                        end
                        OP_UMT:
                        begin
                            wr_data = uprod[7:0];
                            ovf     = |uprod[15:8];
                        end
                        OP_SMT:
                        begin
                            wr_data = sprod[7:0];
                            // fits in 8 signed bits only if the top 9 bits agree
                            ovf     = !((&sprod[15:7]) || !(|sprod[15:7]));
                        end
                        OP_AND:  wr_data = dest_val & op_b;
                        OP_OR:   wr_data = dest_val | op_b;
                        default: wr_data = dest_val ^ op_b;
                    endcase
                end
            end
            default:
            begin
                st = ST_BAD_OP;
            end
        endcase

        // flags: write first, overflow on top
        flags_base = (wr_en && wr_idx == REG_FLAGS) ? wr_data : rf_reg[REG_FLAGS];
        flags_next = flags_base | (ovf ? (8'd1 << OVF_BIT) : 8'd0);
        out_reg_next = (wr_en && wr_idx == REG_OUT) ? wr_data : rf_reg[REG_OUT];

        if (halted_reg)
        begin
            // frozen: report current state
            pc_next        = pc_reg;
            halted_next    = 1'b1;
            halt_code_next = halt_code_reg;
            flags_next     = rf_reg[REG_FLAGS];
            out_reg_next   = rf_reg[REG_OUT];
            wr_en          = 1'b0;
            ovf            = 1'b0;
        end
        else if (st != ST_OK)
        begin
            pc_next        = pc_reg;
            halted_next    = 1'b1;
            halt_code_next = st;
        end
        else
        begin
            pc_next        = npc;
            halted_next    = 1'b0;
            halt_code_next = halt_code_reg;
        end

        // register file after this instruction, flag register last
        rf_next = rf_reg;
        if (wr_en)
        begin
            rf_next[wr_idx] = wr_data;
        end
        rf_next[REG_FLAGS] = flags_next;
    end

    // ------------------------------------------------------------------------
    // state update
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg        <= '0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            halt_code_reg <= ST_OK;
        end
        else if (exec)
        begin
            rf_reg        <= rf_next;
            pc_reg        <= pc_next;
            halted_reg    <= halted_next;
            halt_code_reg <= halt_code_next;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            next_pc_reg   <= pc_next;
            data_out_reg  <= out_reg_next;
            flags_now_reg <= flags_next;
            status_reg    <= halted_next ? halt_code_next : ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_pc   = next_pc_reg;
    assign data_out  = data_out_reg;
    assign flags_now = flags_now_reg;
    assign status    = status_reg;

endmodule
